/* rtl/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the escape-coded LZ77 decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

   // Widest history address the design supports (history depth up to 4096).
   localparam int ADDR_MAX_W = 12;

   // Command queue between the parser and the copy engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Results one input item may produce at most.
   localparam logic [6:0] RESULT_CAP = 7'd64;

   // Shortest reference copy.
   localparam logic [6:0] MIN_COPY = 7'd3;

   // Configuration register indexes.
   localparam logic CSR_ESCAPE_BYTE     = 1'b0;
   localparam logic CSR_EXPECTED_LENGTH = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ESCAPE    = 3'd1;
   localparam logic [2:0] ERR_REFERENCE = 3'd2;
   localparam logic [2:0] ERR_LENGTH    = 3'd3;
   localparam logic [2:0] ERR_OVERRUN   = 3'd4;

   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_ERR  = 2'd2,
      CMD_END  = 2'd3
   } cmd_op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
      logic [23:0] produced_count;
      logic        last_of_run;
      logic        stream_end;
   } rsp_type;

   // One classified token, handed from the parser to the copy engine.
   typedef struct packed {
      cmd_op_type            op;
      logic [7:0]            data_byte;
      logic [2:0]            err_code;
      logic [23:0]           count;
      logic [6:0]            copy_len;
      logic                  ref_ok;
      logic [ADDR_MAX_W-1:0] src_addr;
      logic [ADDR_MAX_W-1:0] dst_addr;
      logic                  stream_end;
   } cmd_type;

endpackage

/* rtl/lzd_front.sv */
// ----------------------------------------------------------------------------
// lzd_front
// Parser: accepts compressed bytes, tracks the token state, output count and
// history fill, and turns each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module lzd_front #(
   parameter int HISTORY_DEPTH = 1024,
   parameter int MAX_COPY      = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lzd_pkg::req_type req_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [23:0]      csr_data,
   output logic             cmd_push,
   output lzd_pkg::cmd_type cmd_data,
   input  logic             queue_full
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = AW + 2;

   typedef enum logic [2:0] {
      PH_ANY = 3'b001,
      PH_ESC = 3'b010,
      PH_REF = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      HLT_RUN   = 3'b001,
      HLT_QUIET = 3'b010,
      HLT_ERR   = 3'b100
   } halt_type;

   logic [7:0]    escape_ff;
   logic [23:0]   expected_ff;
   phase_type     phase_ff, phase_in;
   halt_type      halted_ff, halted_in;
   logic [7:0]    held_ff, held_in;
   logic [23:0]   count_ff, count_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] wp_ff, wp_in;

   logic          accept;
   logic [7:0]    in_byte;
   logic          last;
   logic          count_done;
   logic          quiet_pre;
   logic          running;
   logic [6:0]    ref_len;
   logic [10:0]   ref_dist;
   logic          len_bad;
   logic          over;
   logic          ref_ok;
   logic [SW-1:0] src_diff;
   logic [SW-1:0] src_wide;
   logic          do_lit;
   logic          do_copy;
   logic          do_fail;
   logic [2:0]    fail_code;
   logic [7:0]    lit_byte;
   logic [6:0]    adv;
   logic [AW:0]   wp_sum;
   logic [FW:0]   fill_sum;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign in_byte   = req_payload.in_byte;
   assign last      = req_payload.last_in;

   assign count_done = count_ff >= expected_ff;
   assign quiet_pre  = (halted_ff == HLT_RUN) && (phase_ff == PH_ANY) && count_done;
   assign running    = (halted_ff == HLT_RUN) && !quiet_pre;

   // Reference fields: high two bits of the length byte extend the distance.
   assign ref_len  = {1'b0, held_ff[5:0]} + 7'd2;
   assign ref_dist = {1'b0, held_ff[7:6], in_byte} + 11'd1;
   assign len_bad  = (ref_len < lzd_pkg::MIN_COPY) || (ref_len > 7'(MAX_COPY));
   assign over     = ({1'b0, count_ff} + 25'(ref_len)) > {1'b0, expected_ff};
   assign ref_ok   = {{(FW - 10){1'b0}}, ref_dist} <= {1'b0, fill_ff};

   assign src_diff = SW'(wp_ff) - SW'(ref_dist);
   assign src_wide = src_diff[SW-1] ? (src_diff + SW'(HISTORY_DEPTH)) : src_diff;

   always_comb begin
      phase_in  = phase_ff;
      halted_in = halted_ff;
      held_in   = held_ff;
      do_lit    = 1'b0;
      do_copy   = 1'b0;
      do_fail   = 1'b0;
      fail_code = lzd_pkg::ERR_NONE;
      lit_byte  = in_byte;
      if (quiet_pre) begin
         halted_in = HLT_QUIET;
      end
      if (running) begin
         unique case (phase_ff)
            PH_ANY: begin
               if (in_byte == escape_ff) begin
                  if (last) begin
                     do_fail   = 1'b1;
                     fail_code = lzd_pkg::ERR_ESCAPE;
                  end else begin
                     phase_in = PH_ESC;
                  end
               end else begin
                  do_lit = 1'b1;
               end
            end
            PH_ESC: begin
               if (in_byte == 8'd0) begin
                  phase_in = PH_ANY;
                  if (count_done) begin
                     do_fail   = 1'b1;
                     fail_code = lzd_pkg::ERR_OVERRUN;
                  end else begin
                     do_lit   = 1'b1;
                     lit_byte = escape_ff;
                  end
               end else if (last) begin
                  do_fail   = 1'b1;
                  fail_code = lzd_pkg::ERR_REFERENCE;
               end else begin
                  held_in  = in_byte;
                  phase_in = PH_REF;
               end
            end
            PH_REF: begin
               phase_in = PH_ANY;
               if (len_bad) begin
                  do_fail   = 1'b1;
                  fail_code = lzd_pkg::ERR_LENGTH;
               end else if (over) begin
                  do_fail   = 1'b1;
                  fail_code = lzd_pkg::ERR_OVERRUN;
               end else begin
                  do_copy = 1'b1;
               end
            end
            default: begin
               phase_in = PH_ANY;
            end
         endcase
         if (do_fail) begin
            halted_in = HLT_ERR;
            phase_in  = PH_ANY;
         end
      end

      if (do_lit) begin
         adv = 7'd1;
      end else if (do_copy) begin
         adv = ref_len;
      end else begin
         adv = 7'd0;
      end
      count_in = count_ff + 24'(adv);

      // A token that reaches the expected length stops decoding quietly.
      if ((halted_in == HLT_RUN) && (phase_in == PH_ANY) && (count_in >= expected_ff)) begin
         halted_in = HLT_QUIET;
      end
   end

   assign wp_sum   = (AW + 1)'(wp_ff) + (AW + 1)'(adv);
   assign wp_in    = (wp_sum >= (AW + 1)'(HISTORY_DEPTH)) ?
                     AW'(wp_sum - (AW + 1)'(HISTORY_DEPTH)) : wp_sum[AW-1:0];
   assign fill_sum = (FW + 1)'(fill_ff) + (FW + 1)'(adv);
   assign fill_in  = (fill_sum > (FW + 1)'(HISTORY_DEPTH)) ?
                     FW'(HISTORY_DEPTH) : fill_sum[FW-1:0];

   assign cmd_push = accept && (do_lit || do_copy || do_fail || last);

   always_comb begin
      cmd_data            = '0;
      cmd_data.data_byte  = lit_byte;
      cmd_data.err_code   = fail_code;
      cmd_data.count      = count_ff;
      cmd_data.copy_len   = ref_len;
      cmd_data.ref_ok     = ref_ok;
      cmd_data.src_addr   = lzd_pkg::ADDR_MAX_W'(src_wide[AW-1:0]);
      cmd_data.dst_addr   = lzd_pkg::ADDR_MAX_W'(wp_ff);
      cmd_data.stream_end = last;
      if (do_lit) begin
         cmd_data.op = lzd_pkg::CMD_LIT;
      end else if (do_copy) begin
         cmd_data.op = lzd_pkg::CMD_COPY;
      end else if (do_fail) begin
         cmd_data.op = lzd_pkg::CMD_ERR;
      end else begin
         cmd_data.op = lzd_pkg::CMD_END;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= 8'd1;
         expected_ff <= 24'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            lzd_pkg::CSR_ESCAPE_BYTE:     escape_ff   <= csr_data[7:0];
            lzd_pkg::CSR_EXPECTED_LENGTH: expected_ff <= csr_data;
            default:                      expected_ff <= expected_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ANY;
         halted_ff <= HLT_RUN;
         held_ff   <= 8'd0;
         count_ff  <= 24'd0;
         fill_ff   <= '0;
         wp_ff     <= '0;
      end else if (accept) begin
         if (last) begin
            // The end of a stream returns the parser state, but not its configuration, to reset.
            phase_ff  <= PH_ANY;
            halted_ff <= HLT_RUN;
            held_ff   <= 8'd0;
            count_ff  <= 24'd0;
            fill_ff   <= '0;
            wp_ff     <= '0;
         end else begin
            phase_ff  <= phase_in;
            halted_ff <= halted_in;
            held_ff   <= held_in;
            count_ff  <= count_in;
            fill_ff   <= fill_in;
            wp_ff     <= wp_in;
         end
      end
   end

   a_copy_len_legal : assert property (@(posedge clock) disable iff (reset)
      cmd_push && (cmd_data.op == lzd_pkg::CMD_COPY) |->
         (cmd_data.copy_len >= lzd_pkg::MIN_COPY) && (cmd_data.copy_len <= 7'(MAX_COPY)))
      else $error("copy command with a length outside the legal range");

   a_halt_no_cmd : assert property (@(posedge clock) disable iff (reset)
      accept && (halted_ff != HLT_RUN) && !last |-> !cmd_push)
      else $error("halted parser issued a command for a dropped item");

endmodule

/* rtl/lzd_queue.sv */
// ----------------------------------------------------------------------------
// lzd_queue
// Small command FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lzd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output lzd_pkg::cmd_type pop_data,
   output logic             empty
);

   localparam int PW = lzd_pkg::QUEUE_PTR_W;

   lzd_pkg::cmd_type entry_ff [lzd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      level_ff, level_in;

   assign full     = level_ff == (PW + 1)'(lzd_pkg::QUEUE_DEPTH);
   assign empty    = level_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command queue read while empty");

endmodule

/* rtl/lzd_back.sv */
// ----------------------------------------------------------------------------
// lzd_back
// Copy engine: owns the history memory, expands each command into result
// beats, and drives the registered result channel.
// ----------------------------------------------------------------------------
module lzd_back #(
   parameter int HISTORY_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lzd_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lzd_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   typedef struct packed {
      lzd_pkg::rsp_type res;
      logic             emit;
      logic             wr;
      logic             use_mem;
      logic [AW-1:0]    addr;
   } beat_type;

   logic [7:0]       hist_mem [HISTORY_DEPTH];

   logic             busy_ff, busy_in;
   lzd_pkg::cmd_type cmd_ff;
   logic [6:0]       idx_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    wr_ptr_ff;
   logic             d_valid_ff, d_valid_in;
   beat_type         d_ff, beat;
   logic [7:0]       rd_data_ff;
   logic             byp_ff;
   logic [7:0]       byp_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lzd_pkg::rsp_type rsp_ff;

   logic             out_take;
   logic             d_go;
   logic             d_free;
   logic [7:0]       d_byte;
   lzd_pkg::rsp_type d_res;
   logic             hist_we;
   logic             gen;
   logic             is_copy;
   logic [6:0]       emit_cnt;
   logic             copy_done;
   logic             done;
   logic             rd_en;
   logic             load;

   // A read that hits the address written in the same cycle takes the new byte.
   assign d_byte   = d_ff.use_mem ? (byp_ff ? byp_data_ff : rd_data_ff) : d_ff.res.data_byte;
   assign out_take = !rsp_valid_ff || rsp_ready;
   assign d_go     = d_valid_ff && (!d_ff.emit || out_take);
   assign d_free   = !d_valid_ff || d_go;
   assign hist_we  = d_go && d_ff.wr;

   always_comb begin
      d_res           = d_ff.res;
      d_res.data_byte = d_byte;
   end

   assign gen       = busy_ff && d_free;
   assign is_copy   = cmd_ff.op == lzd_pkg::CMD_COPY;
   assign emit_cnt  = (cmd_ff.copy_len > lzd_pkg::RESULT_CAP) ?
                      lzd_pkg::RESULT_CAP : cmd_ff.copy_len;
   assign copy_done = idx_ff == (cmd_ff.copy_len - 7'd1);
   assign done      = !is_copy || copy_done;
   assign rd_en     = gen && is_copy && cmd_ff.ref_ok;
   assign load      = cmd_valid && (!busy_ff || (gen && done));
   assign cmd_pop   = load;

   always_comb begin
      beat                    = '0;
      beat.addr               = wr_ptr_ff;
      beat.res.produced_count = cmd_ff.count;
      unique case (cmd_ff.op)
         lzd_pkg::CMD_LIT: begin
            beat.res.kind           = lzd_pkg::KIND_DATA;
            beat.res.data_byte      = cmd_ff.data_byte;
            beat.res.produced_count = cmd_ff.count + 24'd1;
            beat.wr                 = 1'b1;
         end
         lzd_pkg::CMD_COPY: begin
            beat.res.kind           = lzd_pkg::KIND_DATA;
            beat.res.produced_count = cmd_ff.count + 24'(idx_ff) + 24'd1;
            beat.wr                 = 1'b1;
            beat.use_mem            = cmd_ff.ref_ok;
         end
         lzd_pkg::CMD_ERR: begin
            beat.res.kind       = lzd_pkg::KIND_ERROR;
            beat.res.error_code = cmd_ff.err_code;
         end
         default: begin
            beat.res.kind = lzd_pkg::KIND_END;
         end
      endcase
      // A copy byte past the result cap still enters the history.
      beat.emit            = !is_copy || (idx_ff < lzd_pkg::RESULT_CAP);
      beat.res.last_of_run = !is_copy || (idx_ff == (emit_cnt - 7'd1));
      beat.res.stream_end  = cmd_ff.stream_end && beat.res.last_of_run;
   end

   always_comb begin
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (gen && done) begin
         busy_in = 1'b0;
      end
   end

   assign d_valid_in = gen ? 1'b1 : (d_go ? 1'b0 : d_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (d_go && d_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff    <= cmd_data;
         idx_ff    <= 7'd0;
         rd_ptr_ff <= cmd_data.src_addr[AW-1:0];
         wr_ptr_ff <= cmd_data.dst_addr[AW-1:0];
      end else if (gen) begin
         idx_ff    <= idx_ff + 7'd1;
         rd_ptr_ff <= (rd_ptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
         wr_ptr_ff <= (wr_ptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (gen) begin
         d_ff <= beat;
      end
      if (d_go && d_ff.emit) begin
         rsp_ff <= d_res;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[d_ff.addr] <= d_byte;
      end
      if (rd_en) begin
         rd_data_ff  <= hist_mem[rd_ptr_ff];
         byp_ff      <= hist_we && (d_ff.addr == rd_ptr_ff);
         byp_data_ff <= d_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_beat_holds : assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && !d_go |=> d_valid_ff && $stable(d_ff))
      else $error("stalled result beat was lost or changed");

   a_read_feeds_beat : assert property (@(posedge clock) disable iff (reset)
      rd_en |=> d_valid_ff && d_ff.use_mem)
      else $error("history read without a beat to consume it");

endmodule

/* rtl/lz77_escape_decompressor_top.sv */
// Throughput: one literal item per cycle; a reference emits one copied byte per cycle
// (history read port) unless rsp_ready stalls, and holds the copy engine until done.
// Items keep being accepted while the four-entry command queue has room.
// Reset is synchronous and clears all control state and both registers to their
// reset values; the history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// lz77_escape_decompressor_top
// Escape-coded LZ77 decompressor with a parser front end, a command queue and
// a history copy engine.
// ----------------------------------------------------------------------------
module lz77_escape_decompressor_top #(
   parameter int HISTORY_DEPTH = 1024,
   parameter int MAX_COPY      = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lzd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lzd_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [23:0]      csr_data
);

   logic             cmd_push;
   lzd_pkg::cmd_type cmd_push_data;
   logic             queue_full;
   logic             queue_empty;
   logic             cmd_pop;
   lzd_pkg::cmd_type cmd_pop_data;

   lzd_front #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .MAX_COPY     (MAX_COPY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_push_data),
      .queue_full (queue_full)
   );

   lzd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_push_data),
      .full     (queue_full),
      .pop      (cmd_pop),
      .pop_data (cmd_pop_data),
      .empty    (queue_empty)
   );

   lzd_back #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd_data   (cmd_pop_data),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
